// File: src/lgdr_pkg.sv
`default_nettype none

package lgdr_pkg;

   localparam int RUN_W = 4;
   localparam int SIDE_W = 4;
   localparam int MAX_SIDE_DEFAULT = 8;

   typedef logic [RUN_W-1:0] run_type;
   typedef logic [SIDE_W-1:0] side_type;

   localparam side_type SIDE_RESET = side_type'(5);

   typedef struct packed {
      logic step;
      logic clear;
      logic cell_bit;
   } core_ctrl_type;

   typedef struct packed {
      logic    last;
      run_type best;
   } core_status_type;

endpackage

`default_nettype wire

// File: src/longest_diagonal_run.sv
// A request's cell is registered at acceptance and processed from that register; the result of
// the last cell of a matrix enters the output register when that cell is processed and stays
// there until it is taken. Throughput: one request per cycle while no side length write is
// pending; only the last cell of a matrix waits for a held result.
// Reset clears the counters, line stores, running maximum and both valid flags and sets
// the side length to 5; a side length write clears the matrix state the same way.
`default_nettype none

module longest_diagonal_run #(
   parameter int MAX_SIDE = lgdr_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cell_bit,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output lgdr_pkg::run_type        rsp_longest_run,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire lgdr_pkg::side_type  csr_side_length
);

   lgdr_pkg::side_type        side_ff, side_in;
   logic                      valid_ff, valid_in;
   logic                      cell_ff, cell_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lgdr_pkg::run_type         longest_run_ff, longest_run_in;
   lgdr_pkg::core_ctrl_type   ctrl;
   lgdr_pkg::core_status_type status;
   logic                      proceed, csr_write, req_take;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign proceed   = valid_ff && (!status.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = (!valid_ff || proceed) && !csr_valid;
   assign req_take  = req_valid && req_ready;

   assign ctrl.step     = proceed && !csr_write;
   assign ctrl.clear    = csr_write;
   assign ctrl.cell_bit = cell_ff;

   lgdr_core #(
      .MAX_SIDE (MAX_SIDE)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .side   (side_ff),
      .ctrl   (ctrl),
      .status (status)
   );

   always_comb begin
      side_in        = side_ff;
      valid_in       = valid_ff;
      cell_in        = cell_ff;
      rsp_valid_in   = rsp_valid_ff;
      longest_run_in = longest_run_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_write) begin
         side_in  = csr_side_length;
         valid_in = 1'b0;
      end else begin
         if (proceed) begin
            valid_in = 1'b0;
            if (status.last) begin
               rsp_valid_in   = 1'b1;
               longest_run_in = status.best;
            end
         end
         if (req_take) begin
            valid_in = 1'b1;
            cell_in  = req_cell_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= lgdr_pkg::SIDE_RESET;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_ff      <= side_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cell_ff        <= cell_in;
      longest_run_ff <= longest_run_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = longest_run_ff;

endmodule

`default_nettype wire

// File: src/lgdr_core.sv
`default_nettype none

module lgdr_core #(
   parameter int MAX_SIDE = lgdr_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lgdr_pkg::side_type       side,
   input  wire lgdr_pkg::core_ctrl_type  ctrl,
   output lgdr_pkg::core_status_type     status
);

   // Runs never exceed the effective side, which the 4-bit register caps at 15.
   localparam int LINE_DEPTH = (MAX_SIDE < 15) ? MAX_SIDE : 15;
   localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam lgdr_pkg::side_type DEPTH_LIMIT = lgdr_pkg::side_type'(LINE_DEPTH);

   lgdr_pkg::side_type n;
   lgdr_pkg::side_type col_ff, col_in, row_ff, row_in;
   lgdr_pkg::side_type col_plus;
   lgdr_pkg::run_type  dr_ff [LINE_DEPTH];
   lgdr_pkg::run_type  dr_in [LINE_DEPTH];
   lgdr_pkg::run_type  dl_ff [LINE_DEPTH];
   lgdr_pkg::run_type  dl_in [LINE_DEPTH];
   lgdr_pkg::run_type  saved_ff, saved_in, best_ff, best_in;
   lgdr_pkg::run_type  upper_left, upper_right, dr, dl, best_step;
   logic [IDX_W-1:0]   idx, idx_right;
   logic               col_last, row_last, matrix_last, wipe;

   always_comb begin
      if (side == '0) begin
         n = lgdr_pkg::side_type'(1);
      end else if (side > DEPTH_LIMIT) begin
         n = DEPTH_LIMIT;
      end else begin
         n = side;
      end
   end

   assign col_plus    = col_ff + lgdr_pkg::side_type'(1);
   assign idx         = col_ff[IDX_W-1:0];
   assign idx_right   = col_plus[IDX_W-1:0];
   assign col_last    = ({1'b0, col_ff} + 5'd1) >= {1'b0, n};
   assign row_last    = ({1'b0, row_ff} + 5'd1) >= {1'b0, n};
   assign matrix_last = col_last && row_last;

   assign upper_left  = (col_ff != '0) ? saved_ff : '0;
   assign upper_right = (!col_last) ? dl_ff[idx_right] : '0;
   assign dr = ctrl.cell_bit ? upper_left + lgdr_pkg::run_type'(1) : '0;
   assign dl = ctrl.cell_bit ? upper_right + lgdr_pkg::run_type'(1) : '0;

   always_comb begin
      best_step = best_ff;
      if (dr > best_step) begin
         best_step = dr;
      end
      if (dl > best_step) begin
         best_step = dl;
      end
   end

   assign status.last = matrix_last;
   assign status.best = best_step;

   assign wipe = ctrl.clear || (ctrl.step && matrix_last);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      saved_in = saved_ff;
      best_in  = best_ff;
      dr_in    = dr_ff;
      dl_in    = dl_ff;
      if (wipe) begin
         col_in   = '0;
         row_in   = '0;
         saved_in = '0;
         best_in  = '0;
         for (int i = 0; i < LINE_DEPTH; i++) begin
            dr_in[i] = '0;
            dl_in[i] = '0;
         end
      end else if (ctrl.step) begin
         best_in    = best_step;
         dr_in[idx] = dr;
         dl_in[idx] = dl;
         if (col_last) begin
            col_in   = '0;
            row_in   = row_ff + lgdr_pkg::side_type'(1);
            saved_in = '0;
         end else begin
            col_in   = col_plus;
            saved_in = dr_ff[idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         saved_ff <= '0;
         best_ff  <= '0;
         for (int i = 0; i < LINE_DEPTH; i++) begin
            dr_ff[i] <= '0;
            dl_ff[i] <= '0;
         end
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         saved_ff <= saved_in;
         best_ff  <= best_in;
         dr_ff    <= dr_in;
         dl_ff    <= dl_in;
      end
   end

endmodule

`default_nettype wire

// File: test/longest_diagonal_run_checker.sv
`default_nettype none

module longest_diagonal_run_checker #(
   parameter int MAX_SIDE = lgdr_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_cell_bit,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire lgdr_pkg::run_type  rsp_longest_run,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire lgdr_pkg::side_type csr_side_length,
   output int                      fail_count,
   output int                      pending,
   output int                      checked_count
);

   lgdr_pkg::side_type side_reg = lgdr_pkg::SIDE_RESET;
   lgdr_pkg::run_type  dr_line [MAX_SIDE];
   lgdr_pkg::run_type  dl_line [MAX_SIDE];
   lgdr_pkg::run_type  upleft;
   lgdr_pkg::run_type  best;
   int                 row;
   int                 col;
   lgdr_pkg::run_type  longest_q [$];
   int                 fails = 0;
   int                 checked = 0;

   task automatic clear_matrix();
      row = 0;
      col = 0;
      upleft = '0;
      best = '0;
      for (int i = 0; i < MAX_SIDE; i++) begin
         dr_line[i] = '0;
         dl_line[i] = '0;
      end
   endtask

   task automatic track_cell(input logic bit_value);
      int                n;
      int                c;
      lgdr_pkg::run_type ul;
      lgdr_pkg::run_type ur;
      lgdr_pkg::run_type dr;
      lgdr_pkg::run_type dl;
      n = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
      c = (col >= MAX_SIDE) ? MAX_SIDE - 1 : col;
      ul = (c > 0) ? upleft : lgdr_pkg::run_type'(0);
      ur = (c + 1 < n) ? dl_line[c+1] : lgdr_pkg::run_type'(0);
      dr = bit_value ? lgdr_pkg::run_type'(ul + 1) : lgdr_pkg::run_type'(0);
      dl = bit_value ? lgdr_pkg::run_type'(ur + 1) : lgdr_pkg::run_type'(0);
      upleft = dr_line[c];
      dr_line[c] = dr;
      dl_line[c] = dl;
      if (dr > best) best = dr;
      if (dl > best) best = dl;
      if (c + 1 >= n) begin
         if (row + 1 >= n) begin
            longest_q.push_back(best);
            clear_matrix();
         end else begin
            col = 0;
            row = row + 1;
            upleft = '0;
         end
      end else begin
         col = c + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         side_reg = lgdr_pkg::SIDE_RESET;
         clear_matrix();
         longest_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            side_reg = csr_side_length;
            clear_matrix();
         end
         if (req_valid && req_ready) track_cell(req_cell_bit);
         if (rsp_valid && rsp_ready) begin
            if (longest_q.size() == 0) begin
               $display("%0t: unexpected longest_run result, expected none, actual %0d",
                        $time, rsp_longest_run);
               fails++;
            end else begin
               lgdr_pkg::run_type want;
               want = longest_q.pop_front();
               checked++;
               if (rsp_longest_run !== want) begin
                  $display("%0t: longest_run mismatch, expected %0d, actual %0d",
                           $time, want, rsp_longest_run);
                  fails++;
               end
            end
         end
      end
      fail_count <= fails;
      pending <= longest_q.size();
      checked_count <= checked;
   end

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;

   localparam int LIMIT = 400000;
   localparam int TARGET_CELLS = 1750;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cell_bit = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   lgdr_pkg::run_type  rsp_longest_run;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   lgdr_pkg::side_type csr_side_length = '0;

   int fail_count;
   int pending;
   int checked_count;
   int send_idle = 35;
   int take_idle = 64;
   int cells_sent = 0;
   int side_writes = 0;
   int cycles = 0;
   int side_now = 5;

   always #5 clock = ~clock;

   longest_diagonal_run dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_bit    (req_cell_bit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_longest_run (rsp_longest_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_side_length (csr_side_length)
   );

   longest_diagonal_run_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_bit    (req_cell_bit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_longest_run (rsp_longest_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_side_length (csr_side_length),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked_count   (checked_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_cell(input logic bit_value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_bit <= bit_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cells_sent++;
   endtask

   task automatic quiesce(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_side(input lgdr_pkg::side_type value);
      quiesce(4);
      csr_valid <= 1'b1;
      csr_side_length <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      side_writes++;
      side_now = (value == 0) ? 1 : ((value > 8) ? 8 : int'(value));
   endtask

   task automatic send_cells(input int count, input int density);
      for (int i = 0; i < count; i++) send_cell($urandom_range(99) < density);
   endtask

   initial begin
      int matrices;
      int density;
      int phase;
      lgdr_pkg::side_type value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A full matrix of ones at the reset side length, then the smallest sides,
      // a side length of zero, and an abandoned partial matrix.
      send_cells(25, 100);
      write_side(lgdr_pkg::side_type'(1));
      send_cell(1'b1);
      write_side(lgdr_pkg::side_type'(0));
      send_cell(1'b0);
      write_side(lgdr_pkg::side_type'(2));
      send_cell(1'b1);
      send_cell(1'b1);
      write_side(lgdr_pkg::side_type'(2));
      send_cell(1'b0);
      send_cell(1'b1);
      send_cell(1'b1);
      send_cell(1'b0);

      phase = 0;
      while (cells_sent < TARGET_CELLS) begin
         if (cells_sent < 650) begin
            send_idle = 35;
            take_idle = 64;
         end else if (cells_sent < 1250) begin
            send_idle = 64;
            take_idle = 35;
         end else begin
            send_idle = 0;
            take_idle = 0;
         end
         case (phase)
            0: value = lgdr_pkg::side_type'(15);
            1: value = lgdr_pkg::side_type'(1);
            2: value = lgdr_pkg::side_type'(0);
            3: value = lgdr_pkg::side_type'(8);
            4: value = lgdr_pkg::side_type'(9);
            default: value = lgdr_pkg::side_type'($urandom_range(0, 15));
         endcase
         write_side(value);
         matrices = $urandom_range(1, 4);
         for (int m = 0; m < matrices; m++) begin
            case ($urandom_range(3))
               0: density = 15;
               1: density = 50;
               2: density = 85;
               default: density = 100;
            endcase
            send_cells(side_now * side_now, density);
            if (phase == 3 && m == 0) quiesce(0);
         end
         if (side_now > 1 && $urandom_range(2) == 0)
            send_cells($urandom_range(1, side_now * side_now - 1), 70);
         phase++;
      end

      quiesce(8);
      $display("Sent %0d cells over %0d side length writes; %0d matrix results checked.",
               cells_sent, side_writes, checked_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
src/lgdr_pkg.sv
src/lgdr_core.sv
src/longest_diagonal_run.sv
test/longest_diagonal_run_checker.sv
test/tb.sv
